>>> src/dts_pkg.sv
`timescale 1ns / 1ps

package dts_pkg;

  // defaults for the top level parameters
  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int INDEX_WIDTH_DEF      = 20;

  // field widths
  localparam int FREQ_W      = 15;
  localparam int PSTEP_W     = 32;
  localparam int COUNT_W     = 20;
  localparam int ESTEP_W     = 16;
  localparam int PHASE_W     = 33;
  localparam int ENV_W       = 16;
  localparam int SAMPLE_W    = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int MIX_W       = 32;
  localparam int ACC_W       = 49;
  localparam int SCALED_W    = 18;

  // register reset values
  localparam logic [FREQ_W-1:0]  FREQ_RST   = 15'd500;
  localparam logic [PSTEP_W-1:0] PSTEP_RST  = 32'd48695733;
  localparam logic [COUNT_W-1:0] COUNT_RST  = 20'd4410;
  localparam logic [ESTEP_W-1:0] ESTEP_RST  = 16'd15;

  localparam logic [FREQ_W-1:0]        HALF_ENABLE_HZ = 15'd200;
  localparam logic [ENV_W-1:0]         ENV_FULL       = 16'hFFFF;
  localparam logic signed [15:0]       GAIN_MAIN      = 16'sd9830;
  localparam logic signed [15:0]       GAIN_HALF      = 16'sd3277;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX   = 16'sh7FFF;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN   = 16'sh8000;

  // sine polynomial coefficients, Q30
  localparam longint unsigned Q30_ONE = 64'd1073741824;
  localparam longint unsigned SIN_C1  = 64'd1686629713;
  localparam longint unsigned SIN_C3  = 64'd693598669;
  localparam longint unsigned SIN_C5  = 64'd85569306;
  localparam longint unsigned SIN_C7  = 64'd5026995;
  localparam longint unsigned SIN_C9  = 64'd172272;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FREQUENCY_HZ  = 2'd0,
    REG_PHASE_STEP    = 2'd1,
    REG_SAMPLE_COUNT  = 2'd2,
    REG_ENVELOPE_STEP = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LOOKUP = 2'd1,
    ST_MIX    = 2'd2,
    ST_FINISH = 2'd3
  } state_t;

  typedef struct packed {
    logic cfg_we;
    logic accept;
    logic finish;
  } cmd_t;

  // q15 sine of a 32-bit angle held in the low bits of f, elaboration only
  function automatic logic signed [15:0] sine_entry(input longint unsigned f);
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned s;
    longint unsigned r;
    logic [1:0]      quad;
    logic signed [15:0] rv;
    quad = f[31:30];
    x = f & (Q30_ONE - 64'd1);
    if (quad[0]) begin
      x = Q30_ONE - x;
    end
    x2 = (x * x) >> 30;
    p  = SIN_C9;
    p  = SIN_C7 - ((x2 * p) >> 30);
    p  = SIN_C5 - ((x2 * p) >> 30);
    p  = SIN_C3 - ((x2 * p) >> 30);
    p  = SIN_C1 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    r  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    rv = 16'(r);
    return quad[1] ? -rv : rv;
  endfunction

endpackage

>>> src/dts_sine_rom.sv
`timescale 1ns / 1ps

module dts_sine_rom #(
  parameter int SINE_TABLE_DEPTH = dts_pkg::SINE_TABLE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic [31:0]        phase_main,
  input  logic [31:0]        phase_half,
  output logic signed [15:0] sin_main,
  output logic signed [15:0] sin_half
);

  localparam int ADDR_W  = (SINE_TABLE_DEPTH > 1) ? $clog2(SINE_TABLE_DEPTH) : 1;
  localparam int DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W  = 32 + DEPTH_W;

  logic signed [15:0] rom [SINE_TABLE_DEPTH];
  logic [PROD_W-1:0]  prod_main;
  logic [PROD_W-1:0]  prod_half;
  logic [ADDR_W-1:0]  addr_main;
  logic [ADDR_W-1:0]  addr_half;

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam longint unsigned ANGLE = (longint'(k) << 32) / SINE_TABLE_DEPTH;
    assign rom[k] = dts_pkg::sine_entry(ANGLE);
  end

  // table index = phase * depth / 2^32
  assign prod_main = PROD_W'(phase_main) * PROD_W'(SINE_TABLE_DEPTH);
  assign prod_half = PROD_W'(phase_half) * PROD_W'(SINE_TABLE_DEPTH);
  assign addr_main = prod_main[32 +: ADDR_W];
  assign addr_half = prod_half[32 +: ADDR_W];

  always_ff @(posedge clk) begin
    sin_main <= rom[addr_main];
    sin_half <= rom[addr_half];
  end

endmodule

>>> src/dts_ctrl.sv
`timescale 1ns / 1ps

module dts_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  output dts_pkg::cmd_t cmd
);

  dts_pkg::state_t state;
  dts_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= dts_pkg::ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.finish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      dts_pkg::ST_IDLE:   if (in_valid) state_next = dts_pkg::ST_LOOKUP;
      dts_pkg::ST_LOOKUP: state_next = dts_pkg::ST_MIX;
      dts_pkg::ST_MIX:    state_next = dts_pkg::ST_FINISH;
      dts_pkg::ST_FINISH: if (out_free) state_next = dts_pkg::ST_IDLE;
      default:            state_next = dts_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = 1'b0;
    cmd.finish = 1'b0;
    unique case (state)
      dts_pkg::ST_IDLE:   in_ready = 1'b1;
      dts_pkg::ST_LOOKUP: ;
      dts_pkg::ST_MIX:    ;
      dts_pkg::ST_FINISH: cmd.finish = out_free;
      default:            ;
    endcase
    cmd.accept = in_ready && in_valid;
    cmd.cfg_we = cfg_valid;
    cfg_ready  = 1'b1;
  end

endmodule

>>> src/dts_datapath.sv
`timescale 1ns / 1ps

module dts_datapath #(
  parameter int SINE_TABLE_DEPTH = dts_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int INDEX_WIDTH      = dts_pkg::INDEX_WIDTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  dts_pkg::cmd_t                         cmd,
  input  logic                                  start_req,
  input  logic [dts_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [dts_pkg::CFG_DATA_W-1:0]        cfg_data,
  output logic signed [dts_pkg::SAMPLE_W-1:0]   sample,
  output logic                                  done_res
);

  localparam longint unsigned INDEX_MAX = (64'd1 << INDEX_WIDTH) - 64'd1;
  localparam longint unsigned IDX_RST   =
    (64'(dts_pkg::COUNT_RST) > INDEX_MAX) ? INDEX_MAX : 64'(dts_pkg::COUNT_RST);
  localparam int CMP_W = (INDEX_WIDTH > dts_pkg::COUNT_W) ? INDEX_WIDTH : dts_pkg::COUNT_W;
  localparam logic signed [dts_pkg::ACC_W-1:0] ROUND_HALF = 49'sd1073741824;

  logic [dts_pkg::FREQ_W-1:0]    frequency_hz;
  logic [dts_pkg::PSTEP_W-1:0]   phase_step;
  logic [dts_pkg::COUNT_W-1:0]   sample_count;
  logic [dts_pkg::ESTEP_W-1:0]   envelope_step;

  logic [INDEX_WIDTH-1:0]        sample_index;
  logic [dts_pkg::PHASE_W-1:0]   phase_acc;
  logic [dts_pkg::ENV_W-1:0]     envelope_level;

  logic signed [15:0]            sin_main;
  logic signed [15:0]            sin_half;
  logic signed [dts_pkg::MIX_W-1:0] mix;
  logic signed [dts_pkg::MIX_W-1:0] mix_next;
  logic signed [dts_pkg::ACC_W-1:0] acc;
  logic signed [dts_pkg::ACC_W-1:0] biased;
  logic signed [dts_pkg::SCALED_W-1:0] scaled;
  logic signed [dts_pkg::SAMPLE_W-1:0] sat;
  logic                          burst_over;
  logic [dts_pkg::ENV_W-1:0]     env_dec;

  dts_sine_rom #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_rom (
    .clk        (clk),
    .phase_main (phase_acc[31:0]),
    .phase_half (phase_acc[32:1]),
    .sin_main   (sin_main),
    .sin_half   (sin_half)
  );

  // gains folded in before the envelope multiply
  always_comb begin
    mix_next = dts_pkg::MIX_W'(sin_main) * dts_pkg::MIX_W'(dts_pkg::GAIN_MAIN);
    if (frequency_hz > dts_pkg::HALF_ENABLE_HZ) begin
      mix_next = mix_next +
                 dts_pkg::MIX_W'(sin_half) * dts_pkg::MIX_W'(dts_pkg::GAIN_HALF);
    end
  end

  always_ff @(posedge clk) begin
    mix <= mix_next;
  end

  always_comb begin
    acc    = dts_pkg::ACC_W'(mix) * $signed(dts_pkg::ACC_W'(envelope_level));
    biased = acc + ROUND_HALF;
    scaled = dts_pkg::SCALED_W'(biased >>> 31);
    if (scaled > dts_pkg::SCALED_W'(dts_pkg::SAMPLE_MAX)) begin
      sat = dts_pkg::SAMPLE_MAX;
    end else if (scaled < dts_pkg::SCALED_W'(dts_pkg::SAMPLE_MIN)) begin
      sat = dts_pkg::SAMPLE_MIN;
    end else begin
      sat = dts_pkg::SAMPLE_W'(scaled);
    end
    burst_over = (CMP_W'(sample_index) >= CMP_W'(sample_count)) ||
                 (sample_index == {INDEX_WIDTH{1'b1}});
    env_dec = (envelope_level > envelope_step) ? envelope_level - envelope_step : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frequency_hz  <= dts_pkg::FREQ_RST;
      phase_step    <= dts_pkg::PSTEP_RST;
      sample_count  <= dts_pkg::COUNT_RST;
      envelope_step <= dts_pkg::ESTEP_RST;
    end else if (cmd.cfg_we) begin
      unique case (dts_pkg::cfg_reg_t'(cfg_index))
        dts_pkg::REG_FREQUENCY_HZ:  frequency_hz  <= cfg_data[dts_pkg::FREQ_W-1:0];
        dts_pkg::REG_PHASE_STEP:    phase_step    <= cfg_data[dts_pkg::PSTEP_W-1:0];
        dts_pkg::REG_SAMPLE_COUNT:  sample_count  <= cfg_data[dts_pkg::COUNT_W-1:0];
        dts_pkg::REG_ENVELOPE_STEP: envelope_step <= cfg_data[dts_pkg::ESTEP_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_index   <= INDEX_WIDTH'(IDX_RST);
      phase_acc      <= '0;
      envelope_level <= '0;
    end else if (cmd.accept && start_req) begin
      sample_index   <= '0;
      phase_acc      <= '0;
      envelope_level <= dts_pkg::ENV_FULL;
    end else if (cmd.finish && !burst_over) begin
      sample_index   <= sample_index + INDEX_WIDTH'(1);
      phase_acc      <= phase_acc + dts_pkg::PHASE_W'(phase_step);
      envelope_level <= env_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      sample   <= burst_over ? '0 : sat;
      done_res <= burst_over;
    end
  end

endmodule

>>> src/decaying_tone_synth.sv
`timescale 1ns / 1ps
// a result passes the table lookup, gain mix and envelope scale states, the last one waiting for the sink
// a new sample request is taken only in the idle state, once the last one has left the envelope scale state
// the result register frees the input side while a finished sample waits for the sink
// reset: registers take their default settings, the burst counts as over (done until a start)
// no clearing pass; the sine table is constant and needs no fill
module decaying_tone_synth #(
  parameter int SINE_TABLE_DEPTH = dts_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int INDEX_WIDTH      = dts_pkg::INDEX_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  // input channel, one transaction per sample request
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                start_req,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [dts_pkg::SAMPLE_W-1:0] sample,
  output logic                                done_res,
  // register write channel, always ready
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [dts_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [dts_pkg::CFG_DATA_W-1:0]      cfg_data
);

  // commands from the sequencer to the datapath
  dts_pkg::cmd_t cmd;

  // sequencer: idle -> table lookup -> gain mix -> envelope scale and output load
  dts_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cmd       (cmd)
  );

  // datapath: settings, burst state, sine table, multipliers and result register
  dts_datapath #(
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
    .INDEX_WIDTH      (INDEX_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .start_req (start_req),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample),
    .done_res  (done_res)
  );

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps

module tb;

  // predictor sizing follows the block's default parameters
  localparam int TABLE_DEPTH = dts_pkg::SINE_TABLE_DEPTH_DEF;
  localparam int IDX_W       = dts_pkg::INDEX_WIDTH_DEF;
  localparam logic [IDX_W-1:0] INDEX_LAST = '1;

  // run shape
  localparam int PHASES_PER_MODE = 4;
  localparam int ITEMS_PER_PHASE = 138;
  localparam int HOLD_CYCLES     = 400;
  localparam int DRAIN_CYCLES    = 8;
  localparam int DIR_ROWS        = 33;

  // one row of the directed table: a register write or a sample request,
  // with the result typed in only where it is obvious
  typedef struct packed {
    logic                is_cfg;
    dts_pkg::cfg_reg_t   reg_sel;
    logic [31:0]         value;
    logic                start;
    logic                typed;
    logic signed [15:0]  exp_sample;
    logic                exp_done;
  } stim_row_t;

  typedef struct packed {
    logic signed [dts_pkg::SAMPLE_W-1:0] sample;
    logic                                done;
  } tone_result_t;

  localparam stim_row_t DIR_TAB [0:DIR_ROWS-1] = '{
    // out of reset the burst counts as over
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b0, 1'b1, 16'sd0, 1'b1},
    // a start with zero phase gives a zero sample
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b1, 1'b1, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b0, 1'b0, 16'sd0, 1'b0},
    // zero length burst, done even right after a start
    '{1'b1, dts_pkg::REG_SAMPLE_COUNT, 32'd0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b1, 1'b1, 16'sd0, 1'b1},
    // full decrement empties the envelope after one sample
    '{1'b1, dts_pkg::REG_SAMPLE_COUNT, 32'd3, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b1, dts_pkg::REG_ENVELOPE_STEP, 32'd65535, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b1, dts_pkg::REG_FREQUENCY_HZ, 32'd200, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b1, dts_pkg::REG_PHASE_STEP, 32'h4000_0000, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b1, 1'b1, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b0, 1'b1, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b0, 1'b1, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b0, 1'b1, 16'sd0, 1'b1},
    // flat envelope, quarter turn steps through the sine extremes
    '{1'b1, dts_pkg::REG_ENVELOPE_STEP, 32'd0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b1, dts_pkg::REG_SAMPLE_COUNT, 32'hF_FFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b1, 1'b1, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b0, 1'b0, 16'sd0, 1'b0},
    // just above the threshold the half frequency term joins in
    '{1'b1, dts_pkg::REG_FREQUENCY_HZ, 32'd201, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b0, 1'b0, 16'sd0, 1'b0},
    // largest step wraps the 33-bit phase
    '{1'b1, dts_pkg::REG_FREQUENCY_HZ, 32'd32767, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b1, dts_pkg::REG_PHASE_STEP, 32'hFFFF_FFFF, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b1, dts_pkg::REG_ENVELOPE_STEP, 32'd1, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b1, 1'b1, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b0, 1'b0, 16'sd0, 1'b0},
    // count shrunk below the running index ends the burst
    '{1'b1, dts_pkg::REG_SAMPLE_COUNT, 32'd2, 1'b0, 1'b0, 16'sd0, 1'b0},
    '{1'b0, dts_pkg::REG_FREQUENCY_HZ, 32'd0, 1'b0, 1'b1, 16'sd0, 1'b1},
    '{1'b1, dts_pkg::REG_SAMPLE_COUNT, 32'd4410, 1'b0, 1'b0, 16'sd0, 1'b0}
  };

  logic                                clk = 1'b0;
  logic                                rst;
  logic                                in_valid;
  logic                                in_ready;
  logic                                start_req;
  logic                                out_valid;
  logic                                out_ready = 1'b0;
  logic signed [dts_pkg::SAMPLE_W-1:0] sample;
  logic                                done_res;
  logic                                cfg_valid;
  logic                                cfg_ready;
  logic [dts_pkg::CFG_IDX_W-1:0]       cfg_index;
  logic [dts_pkg::CFG_DATA_W-1:0]      cfg_data;

  // predictor copy of the registers
  logic [dts_pkg::FREQ_W-1:0]  cur_freq;
  logic [dts_pkg::PSTEP_W-1:0] cur_pstep;
  logic [dts_pkg::COUNT_W-1:0] cur_count;
  logic [dts_pkg::ESTEP_W-1:0] cur_estep;

  // predictor copy of the burst state
  logic [IDX_W-1:0]            tone_idx;
  logic [dts_pkg::PHASE_W-1:0] tone_phase;
  logic [dts_pkg::ENV_W-1:0]   tone_env;

  tone_result_t pending_samples[$];
  int           mismatch_cnt = 0;

  // idle odds in percent, set per mode by the stimulus
  int in_idle_pct  = 0;
  int out_idle_pct = 0;

  // sink hold-off: the stimulus bumps the request count, the sink counts cycles
  int hold_req  = 0;
  int hold_seen = 0;
  int hold_left = 0;

  decaying_tone_synth DUT (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .start_req (start_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sample    (sample),
    .done_res  (done_res),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // q15 sine of a 32-bit phase, quantized to the table grid first
  function automatic longint tone_sine(input logic [31:0] ph);
    longint unsigned slot;
    longint unsigned ang;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned p;
    longint unsigned s;
    longint unsigned r;
    longint unsigned quad;
    slot = ({32'd0, ph} * 64'(TABLE_DEPTH)) >> 32;
    ang  = (slot << 32) / 64'(TABLE_DEPTH);
    quad = (ang >> 30) & 64'd3;
    x    = ang & (dts_pkg::Q30_ONE - 64'd1);
    // odd quadrants run the angle backwards
    if (quad[0]) begin
      x = dts_pkg::Q30_ONE - x;
    end
    x2 = (x * x) >> 30;
    p  = dts_pkg::SIN_C9;
    p  = dts_pkg::SIN_C7 - ((x2 * p) >> 30);
    p  = dts_pkg::SIN_C5 - ((x2 * p) >> 30);
    p  = dts_pkg::SIN_C3 - ((x2 * p) >> 30);
    p  = dts_pkg::SIN_C1 - ((x2 * p) >> 30);
    s  = (x * p) >> 30;
    r  = (s * 64'd32767 + (64'd1 << 29)) >> 30;
    if (r > 64'd32767) begin
      r = 64'd32767;
    end
    // lower half of the circle is negative
    return quad[1] ? -longint'(r) : longint'(r);
  endfunction

  // next sample of the burst, advancing the predicted state
  task automatic tone_predict(input logic start, output tone_result_t res);
    longint env;
    longint acc;
    longint y;
    if (start) begin
      tone_idx   = '0;
      tone_phase = '0;
      tone_env   = dts_pkg::ENV_FULL;
    end
    if (tone_idx >= cur_count || tone_idx == INDEX_LAST) begin
      // burst over: silent, state frozen
      res.sample = '0;
      res.done   = 1'b1;
    end else begin
      env = longint'(tone_env);
      acc = tone_sine(tone_phase[31:0]) * env * longint'(dts_pkg::GAIN_MAIN);
      if (cur_freq > dts_pkg::HALF_ENABLE_HZ) begin
        acc = acc + tone_sine(tone_phase[32:1]) * env * longint'(dts_pkg::GAIN_HALF);
      end
      // round half up, then clip to q1.15
      y = (acc + 64'sd1073741824) >>> 31;
      if (y > longint'(dts_pkg::SAMPLE_MAX)) begin
        y = longint'(dts_pkg::SAMPLE_MAX);
      end
      if (y < longint'(dts_pkg::SAMPLE_MIN)) begin
        y = longint'(dts_pkg::SAMPLE_MIN);
      end
      res.sample = y[dts_pkg::SAMPLE_W-1:0];
      res.done   = 1'b0;
      tone_idx   = tone_idx + IDX_W'(1);
      tone_phase = tone_phase + {1'b0, cur_pstep};
      tone_env   = (tone_env > cur_estep) ? tone_env - cur_estep : '0;
    end
  endtask

  // block until every predicted sample has come back
  task automatic wait_drained();
    while (pending_samples.size() != 0) begin
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  // register write, only with the block idle
  task automatic write_reg(input dts_pkg::cfg_reg_t sel, input logic [31:0] val);
    in_valid <= 1'b0;
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    do begin
      @(posedge clk);
    end while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (sel)
      dts_pkg::REG_FREQUENCY_HZ:  cur_freq  = val[dts_pkg::FREQ_W-1:0];
      dts_pkg::REG_PHASE_STEP:    cur_pstep = val[dts_pkg::PSTEP_W-1:0];
      dts_pkg::REG_SAMPLE_COUNT:  cur_count = val[dts_pkg::COUNT_W-1:0];
      dts_pkg::REG_ENVELOPE_STEP: cur_estep = val[dts_pkg::ESTEP_W-1:0];
      default: ;
    endcase
  endtask

  // one sample request transaction; the expectation is queued on acceptance
  task automatic send_item(input logic start, input logic typed,
                           input tone_result_t typed_res);
    tone_result_t res;
    // source gaps, redrawn at every idle clock
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    start_req <= start;
    do begin
      @(posedge clk);
    end while (!in_ready);
    tone_predict(start, res);
    if (typed) begin
      res = typed_res;
    end
    pending_samples.push_back(res);
  endtask

  // sink: random back-pressure, plus long hold-offs on request
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
    end
  end

  // result checker against the oldest expectation
  always @(posedge clk) begin : result_check
    tone_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected result transaction: sample %0d done_res %0d", sample, done_res);
        mismatch_cnt++;
      end else begin
        want = pending_samples.pop_front();
        if (sample !== want.sample) begin
          $error("sample: expected %0d, actual %0d", want.sample, sample);
          mismatch_cnt++;
        end
        if (done_res !== want.done) begin
          $error("done_res: expected %0d, actual %0d", want.done, done_res);
          mismatch_cnt++;
        end
      end
    end
  end

  // stimulus
  initial begin
    tone_result_t typed_res;
    int           sent;
    int           burst;
    int           burst_cap;
    logic [31:0]  v_freq;
    logic [31:0]  v_pstep;
    logic [31:0]  v_count;
    logic [31:0]  v_estep;

    rst       = 1'b1;
    in_valid  = 1'b0;
    start_req = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = dts_pkg::REG_FREQUENCY_HZ;
    cfg_data  = '0;

    // predictor starts from the reset settings, burst over
    cur_freq   = dts_pkg::FREQ_RST;
    cur_pstep  = dts_pkg::PSTEP_RST;
    cur_count  = dts_pkg::COUNT_RST;
    cur_estep  = dts_pkg::ESTEP_RST;
    tone_idx   = (dts_pkg::COUNT_RST > INDEX_LAST) ? INDEX_LAST : IDX_W'(dts_pkg::COUNT_RST);
    tone_phase = '0;
    tone_env   = '0;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    in_idle_pct  = 32;
    out_idle_pct = 80;

    // directed table
    for (int i = 0; i < DIR_ROWS; i++) begin
      if (DIR_TAB[i].is_cfg) begin
        write_reg(DIR_TAB[i].reg_sel, DIR_TAB[i].value);
      end else begin
        typed_res.sample = DIR_TAB[i].exp_sample;
        typed_res.done   = DIR_TAB[i].exp_done;
        send_item(DIR_TAB[i].start, DIR_TAB[i].typed, typed_res);
      end
    end

    // random part: three idle modes, several register settings each
    for (int mode = 0; mode < 3; mode++) begin
      case (mode)
        0: begin in_idle_pct = 32; out_idle_pct = 80; end
        1: begin in_idle_pct = 80; out_idle_pct = 32; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      for (int ph = 0; ph < PHASES_PER_MODE; ph++) begin
        // frequency around the half-term threshold and at its extremes
        case ($urandom_range(0, 5))
          0: v_freq = 32'd200;
          1: v_freq = 32'd201;
          2: v_freq = 32'd0;
          3: v_freq = 32'd32767;
          default: v_freq = $urandom_range(0, 32767);
        endcase
        case ($urandom_range(0, 7))
          0: v_pstep = 32'd0;
          1: v_pstep = 32'hFFFF_FFFF;
          default: v_pstep = $urandom;
        endcase
        // mostly short bursts so the done state is reached often
        case ($urandom_range(0, 9))
          0: v_count = 32'd0;
          1: v_count = 32'hF_FFFF;
          2: v_count = 32'd4410;
          default: v_count = $urandom_range(1, 40);
        endcase
        case ($urandom_range(0, 7))
          0: v_estep = 32'd0;
          1: v_estep = 32'd65535;
          2: v_estep = $urandom_range(0, 65535);
          default: v_estep = $urandom_range(0, 65535 / (v_count[19:0] + 1) + 64);
        endcase
        write_reg(dts_pkg::REG_FREQUENCY_HZ, v_freq);
        write_reg(dts_pkg::REG_PHASE_STEP, v_pstep);
        write_reg(dts_pkg::REG_SAMPLE_COUNT, v_count);
        write_reg(dts_pkg::REG_ENVELOPE_STEP, v_estep);

        // with no idling, hold the sink off so the block fills and stalls
        if (mode == 2 && ph == 1) begin
          hold_req++;
        end

        burst_cap = (v_count > 32'd57) ? 60 : int'(v_count) + 3;
        sent = 0;
        while (sent < ITEMS_PER_PHASE) begin
          if ($urandom_range(0, 9) == 0) begin
            // stray request, start or advance
            send_item(1'($urandom_range(0, 1)), 1'b0, typed_res);
            sent++;
          end else begin
            // well formed burst: start, then a run of advances
            send_item(1'b1, 1'b0, typed_res);
            sent++;
            burst = $urandom_range(0, burst_cap);
            while (burst > 0 && sent < ITEMS_PER_PHASE) begin
              send_item(1'b0, 1'b0, typed_res);
              sent++;
              burst--;
            end
          end
        end
      end
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule
